FILE: hdl/isotp_mfr_pkg.sv
// Shared types and constants for the ISO-TP multi-frame reassembler.
// Used by isotp_mfr_ctrl, isotp_mfr_dp and the top level; no dependencies.
package isotp_mfr_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 256;

  localparam int unsigned LEN_W  = 12;
  localparam int unsigned ID_W   = 29;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FRAME_BYTES = 8;

  // mode codes
  localparam logic [1:0] MODE_FIRST  = 2'd0;
  localparam logic [1:0] MODE_CONSEC = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_IGNORED   = 2'd0;
  localparam logic [1:0] ST_STARTED   = 2'd1;
  localparam logic [1:0] ST_CONTINUED = 2'd2;
  localparam logic [1:0] ST_COMPLETE  = 2'd3;

  // PCI high nibble values
  localparam logic [3:0] PCI_FIRST  = 4'h1;
  localparam logic [3:0] PCI_CONSEC = 4'h2;

  // most bytes of payload carried by a first frame
  localparam logic [2:0] FF_CHUNK_MAX = 3'd4;
  // first payload byte position inside each frame type
  localparam logic [2:0] FF_DATA_OFS = 3'd4;
  localparam logic [2:0] CF_DATA_OFS = 3'd1;

  typedef struct packed {
    logic load;     // latch the accepted item
    logic eval;     // decode it and update the session registers
    logic write;    // store one payload byte
    logic publish;  // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic wr_done;  // all payload bytes of this item stored
  } dp_stat_t;

endpackage

FILE: hdl/isotp_mfr_ctrl.sv
// Sequencer for the ISO-TP reassembler: accept, decode, byte writes, publish.
// Depends on isotp_mfr_pkg; drives the datapath isotp_mfr_dp by command struct.
module isotp_mfr_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output isotp_mfr_pkg::ctrl_cmd_t cmd_o,
  input  isotp_mfr_pkg::dp_stat_t  stat_i
);
  import isotp_mfr_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EVAL   = 2'd1;
  localparam logic [1:0] S_WRITE  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_WRITE;
      end
      S_WRITE: begin
        if (stat_i.wr_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.write = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/isotp_mfr_dp.sv
// Datapath for the ISO-TP reassembler: frame latch, session registers,
// payload store and output register. Depends on isotp_mfr_pkg.
module isotp_mfr_dp #(
  parameter int unsigned BUFFER_BYTES = isotp_mfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  isotp_mfr_pkg::ctrl_cmd_t cmd_i,
  output isotp_mfr_pkg::dp_stat_t  stat_o,
  input  logic [1:0]              mode_i,
  input  logic [28:0]             source_id_i,
  input  logic [3:0]              data_length_i,
  input  logic [7:0]              frame_byte0_i,
  input  logic [7:0]              frame_byte1_i,
  input  logic [7:0]              frame_byte2_i,
  input  logic [7:0]              frame_byte3_i,
  input  logic [7:0]              frame_byte4_i,
  input  logic [7:0]              frame_byte5_i,
  input  logic [7:0]              frame_byte6_i,
  input  logic [7:0]              frame_byte7_i,
  input  logic [7:0]              read_index_i,
  output logic [1:0]              status_o,
  output logic [11:0]             message_length_o,
  output logic [7:0]              service_byte_o,
  output logic [7:0]              info_byte_o,
  output logic [11:0]             collected_count_o,
  output logic [7:0]              read_data_o
);
  import isotp_mfr_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  // latched item
  logic [1:0]        mode_q;
  logic [ID_W-1:0]   src_q;
  logic [3:0]        dlen_q;
  logic [BYTE_W-1:0] fb_q [FRAME_BYTES];
  logic [7:0]        ridx_q;

  // session state
  logic              active_q;
  logic [LEN_W-1:0]  total_q;
  logic [BYTE_W-1:0] svc_q;
  logic [BYTE_W-1:0] info_q;
  logic [ID_W-1:0]   sender_q;
  logic [LEN_W-1:0]  count_q;
  logic [3:0]        seq_q;

  // per-item working registers
  logic [LEN_W-1:0]  base_q;
  logic [2:0]        chunk_q;
  logic [2:0]        k_q;
  logic [1:0]        st_q;
  logic              rd_sel_q;
  logic [BYTE_W-1:0] rd_q;

  logic [BYTE_W-1:0] mem_q [BUFFER_BYTES];

  // decode
  logic              ff_ok, cf_ok;
  logic [LEN_W-1:0]  tot_ff, plen_ff, plen_cf, remain, count_cf;
  logic [2:0]        chunk_ff, chunk_cf, avail;
  logic [3:0]        avail_raw;
  logic [LEN_W-1:0]  rd_pos, wr_pos;
  logic [2:0]        byte_sel;
  logic              wr_en;

  always_comb begin
    ff_ok = (mode_q == MODE_FIRST) && dlen_q[3] && (fb_q[0][7:4] == PCI_FIRST);
    cf_ok = (mode_q == MODE_CONSEC) && active_q && (src_q == sender_q) &&
            (dlen_q >= 4'd2) && (fb_q[0][7:4] == PCI_CONSEC) && (fb_q[0][3:0] == seq_q);

    tot_ff   = {fb_q[0][3:0], fb_q[1]};
    plen_ff  = (tot_ff > LEN_W'(2)) ? tot_ff - LEN_W'(2) : '0;
    chunk_ff = (plen_ff < LEN_W'(FF_CHUNK_MAX)) ? plen_ff[2:0] : FF_CHUNK_MAX;

    plen_cf   = (total_q > LEN_W'(2)) ? total_q - LEN_W'(2) : '0;
    remain    = (plen_cf > count_q) ? plen_cf - count_q : '0;
    avail_raw = dlen_q - 4'd1;
    avail     = avail_raw[3] ? 3'd7 : avail_raw[2:0];
    chunk_cf  = (remain < LEN_W'(avail)) ? remain[2:0] : avail;
    count_cf  = count_q + LEN_W'(chunk_cf);
  end

  assign stat_o.wr_done = (k_q == chunk_q);

  assign byte_sel = ((mode_q == MODE_FIRST) ? FF_DATA_OFS : CF_DATA_OFS) + k_q;
  assign wr_pos   = base_q + LEN_W'(k_q);
  assign wr_en    = cmd_i.write && (k_q != chunk_q) && (wr_pos < BUFFER_BYTES);
  assign rd_pos   = LEN_W'(ridx_q);

  // item latch and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      src_q   <= source_id_i;
      dlen_q  <= data_length_i;
      fb_q[0] <= frame_byte0_i;
      fb_q[1] <= frame_byte1_i;
      fb_q[2] <= frame_byte2_i;
      fb_q[3] <= frame_byte3_i;
      fb_q[4] <= frame_byte4_i;
      fb_q[5] <= frame_byte5_i;
      fb_q[6] <= frame_byte6_i;
      fb_q[7] <= frame_byte7_i;
      ridx_q  <= read_index_i;
    end
    if (cmd_i.publish) begin
      status_o          <= st_q;
      message_length_o  <= total_q;
      service_byte_o    <= svc_q;
      info_byte_o       <= info_q;
      collected_count_o <= count_q;
      read_data_o       <= rd_sel_q ? rd_q : '0;
    end
  end

  // payload store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_pos[AW-1:0]] <= fb_q[byte_sel];
    end
    if (cmd_i.eval) begin
      rd_q <= mem_q[rd_pos[AW-1:0]];
    end
  end

  // session registers and byte counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      total_q  <= '0;
      svc_q    <= '0;
      info_q   <= '0;
      sender_q <= '0;
      count_q  <= '0;
      seq_q    <= 4'd1;
      base_q   <= '0;
      chunk_q  <= '0;
      k_q      <= '0;
      st_q     <= ST_IGNORED;
      rd_sel_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        k_q      <= '0;
        rd_sel_q <= (mode_q == MODE_READ) && (rd_pos < BUFFER_BYTES);
        if (ff_ok) begin
          active_q <= 1'b1;
          total_q  <= tot_ff;
          svc_q    <= fb_q[2];
          info_q   <= fb_q[3];
          sender_q <= src_q;
          seq_q    <= 4'd1;
          base_q   <= '0;
          chunk_q  <= chunk_ff;
          count_q  <= LEN_W'(chunk_ff);
          st_q     <= (LEN_W'(chunk_ff) >= plen_ff) ? ST_COMPLETE : ST_STARTED;
        end else if (cf_ok) begin
          seq_q   <= seq_q + 4'd1;
          base_q  <= count_q;
          chunk_q <= chunk_cf;
          count_q <= count_cf;
          st_q    <= (count_cf >= plen_cf) ? ST_COMPLETE : ST_CONTINUED;
        end else begin
          chunk_q <= '0;
          st_q    <= ST_IGNORED;
        end
      end else if (cmd_i.write && (k_q != chunk_q)) begin
        k_q <= k_q + 3'd1;
      end
    end
  end

endmodule

FILE: hdl/isotp_multiframe_reassembler_unit.sv
// ISO-TP multi-frame reassembler, top level.
// Depends on isotp_mfr_pkg, isotp_mfr_ctrl and isotp_mfr_dp.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one CAN frame item: a
//   first frame (mode 0), a consecutive frame (mode 1) or a read request for
//   one stored payload byte (mode 2). Output channel (out_valid_o /
//   out_stall_i) returns exactly one result item per input item, in order.
//   An item is taken at a rising edge with valid high and stall low.
// Timing:
//   One item is worked on at a time. After acceptance the sequencer decodes
//   the item, then writes the frame's payload bytes (0..7) into the store one
//   per cycle (write port of the payload memory), then sees the last write
//   done and publishes the result into the output register once it is free.
//   The next item is taken only after the sequencer is back in idle.
// Stalls:
//   The result sits in an output register, so the next item is accepted
//   while it waits. A further result is held back in the sequencer until the
//   output register is free, and in_stall_o stays high meanwhile.
// Reset:
//   rst_ni (asynchronous, active low) drops any session, sets the expected
//   sequence number to 1 and empties the output register. The payload store
//   is not cleared; positions never written read back undefined.
module isotp_multiframe_reassembler_unit #(
  parameter int unsigned BUFFER_BYTES = isotp_mfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [28:0] source_id_i,
  input  logic [3:0]  data_length_i,
  input  logic [7:0]  frame_byte0_i,
  input  logic [7:0]  frame_byte1_i,
  input  logic [7:0]  frame_byte2_i,
  input  logic [7:0]  frame_byte3_i,
  input  logic [7:0]  frame_byte4_i,
  input  logic [7:0]  frame_byte5_i,
  input  logic [7:0]  frame_byte6_i,
  input  logic [7:0]  frame_byte7_i,
  input  logic [7:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [11:0] message_length_o,
  output logic [7:0]  service_byte_o,
  output logic [7:0]  info_byte_o,
  output logic [11:0] collected_count_o,
  output logic [7:0]  read_data_o
);
  import isotp_mfr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: handshakes and per-item step order
  isotp_mfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // session state, payload store and result register
  isotp_mfr_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .mode_i            (mode_i),
    .source_id_i       (source_id_i),
    .data_length_i     (data_length_i),
    .frame_byte0_i     (frame_byte0_i),
    .frame_byte1_i     (frame_byte1_i),
    .frame_byte2_i     (frame_byte2_i),
    .frame_byte3_i     (frame_byte3_i),
    .frame_byte4_i     (frame_byte4_i),
    .frame_byte5_i     (frame_byte5_i),
    .frame_byte6_i     (frame_byte6_i),
    .frame_byte7_i     (frame_byte7_i),
    .read_index_i      (read_index_i),
    .status_o          (status_o),
    .message_length_o  (message_length_o),
    .service_byte_o    (service_byte_o),
    .info_byte_o       (info_byte_o),
    .collected_count_o (collected_count_o),
    .read_data_o       (read_data_o)
  );

endmodule

FILE: bench/isotp_mfr_tb_pkg.sv
`timescale 1ns / 1ps
// Bench types and session scoreboard for the ISO-TP multi-frame reassembler.
// Depends on isotp_mfr_pkg for codes and sizes.
package isotp_mfr_tb_pkg;
  import isotp_mfr_pkg::*;

  localparam int unsigned STORE_BYTES = BUFFER_BYTES_DEF;
  localparam logic [1:0]  MODE_SPARE  = 2'd3;
  localparam logic [3:0]  SEQ_FIRST   = 4'd1;
  localparam int unsigned CF_DATA_MAX = 7;

  typedef struct packed {
    logic [1:0]      mode;
    logic [28:0]     src;
    logic [3:0]      dlen;
    logic [7:0][7:0] fb;
    logic [7:0]      ridx;
  } frame_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] msg_len;
    logic [7:0]  service;
    logic [7:0]  info;
    logic [11:0] count;
    logic [7:0]  rdata;
  } result_t;

  class reassembly_board;
    bit          active;
    bit [11:0]   total_len;
    bit [7:0]    service;
    bit [7:0]    info;
    bit [28:0]   sender;
    bit [11:0]   collected;
    bit [3:0]    next_seq;
    bit [7:0]    store [STORE_BYTES];
    bit          written [STORE_BYTES];
    int unsigned written_idx [$];
    result_t     pending_q [$];
    int unsigned mismatches;

    function new();
      active      = 1'b0;
      total_len   = '0;
      service     = '0;
      info        = '0;
      sender      = '0;
      collected   = '0;
      next_seq    = SEQ_FIRST;
      mismatches  = 0;
    endfunction

    function int unsigned payload_len();
      return (total_len > 12'd2) ? total_len - 12'd2 : 0;
    endfunction

    // positions past the store are dropped, the count still moves on
    function void put_byte(int unsigned pos, bit [7:0] v);
      if (pos < STORE_BYTES) begin
        store[pos] = v;
        if (!written[pos]) begin
          written[pos] = 1'b1;
          written_idx.push_back(pos);
        end
      end
    endfunction

    // works out the result of an accepted item; returns 1 for a read or an item not ignored
    function bit note_frame(frame_t f);
      result_t     r;
      int unsigned plen;
      int unsigned chunk;
      int unsigned remain;
      int unsigned avail;
      int unsigned i;
      r = '0;
      r.status = ST_IGNORED;
      case (f.mode)
        MODE_FIRST: begin
          if (f.dlen >= 4'd8 && f.fb[0][7:4] == PCI_FIRST) begin
            active    = 1'b1;
            total_len = {f.fb[0][3:0], f.fb[1]};
            service   = f.fb[2];
            info      = f.fb[3];
            sender    = f.src;
            next_seq  = SEQ_FIRST;
            plen      = payload_len();
            chunk     = (plen < FF_CHUNK_MAX) ? plen : FF_CHUNK_MAX;
            for (i = 0; i < chunk; i++) put_byte(i, f.fb[FF_DATA_OFS + i]);
            collected = chunk;
            r.status  = (collected >= plen) ? ST_COMPLETE : ST_STARTED;
          end
        end
        MODE_CONSEC: begin
          if (active && f.src == sender && f.dlen >= 4'd2 &&
              f.fb[0][7:4] == PCI_CONSEC && f.fb[0][3:0] == next_seq) begin
            plen   = payload_len();
            remain = (plen > collected) ? plen - collected : 0;
            avail  = f.dlen - 1;
            if (avail > CF_DATA_MAX) avail = CF_DATA_MAX;
            chunk  = (remain < avail) ? remain : avail;
            for (i = 0; i < chunk; i++) put_byte(collected + i, f.fb[CF_DATA_OFS + i]);
            collected = collected + chunk;
            next_seq  = next_seq + 4'd1;
            r.status  = (collected >= plen) ? ST_COMPLETE : ST_CONTINUED;
          end
        end
        MODE_READ: begin
          if (f.ridx < STORE_BYTES) r.rdata = store[f.ridx];
        end
        default: ;
      endcase
      r.msg_len = total_len;
      r.service = service;
      r.info    = info;
      r.count   = collected;
      pending_q.push_back(r);
      return (r.status != ST_IGNORED) || (f.mode == MODE_READ);
    endfunction

    function void field_check(string name, logic [11:0] want_v, logic [11:0] got_v);
      if (want_v !== got_v) begin
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got 0x%0h", $time, got);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      field_check("status", want.status, got.status);
      field_check("message_length", want.msg_len, got.msg_len);
      field_check("service_byte", want.service, got.service);
      field_check("info_byte", want.info, got.info);
      field_check("collected_count", want.count, got.count);
      field_check("read_data", want.rdata, got.rdata);
    endfunction
  endclass

endpackage

FILE: bench/isotp_multiframe_reassembler_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for isotp_multiframe_reassembler_unit: directed frames,
// then random sessions with idling on both sides. Depends on isotp_mfr_pkg,
// isotp_mfr_tb_pkg and the reassembler RTL.
module isotp_multiframe_reassembler_unit_tb;
  import isotp_mfr_pkg::*;
  import isotp_mfr_tb_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 4;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 24;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = '0;
  logic [28:0] source_id_i = '0;
  logic [3:0]  data_length_i = '0;
  logic [7:0]  frame_byte0_i = '0;
  logic [7:0]  frame_byte1_i = '0;
  logic [7:0]  frame_byte2_i = '0;
  logic [7:0]  frame_byte3_i = '0;
  logic [7:0]  frame_byte4_i = '0;
  logic [7:0]  frame_byte5_i = '0;
  logic [7:0]  frame_byte6_i = '0;
  logic [7:0]  frame_byte7_i = '0;
  logic [7:0]  read_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [11:0] message_length_o;
  logic [7:0]  service_byte_o;
  logic [7:0]  info_byte_o;
  logic [11:0] collected_count_o;
  logic [7:0]  read_data_o;

  reassembly_board board;
  int unsigned     hold_req = 0;  // bumped to ask the receiver for one long hold-off
  int unsigned     calm_left = 0; // items still to send back to back

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  isotp_multiframe_reassembler_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .source_id_i       (source_id_i),
    .data_length_i     (data_length_i),
    .frame_byte0_i     (frame_byte0_i),
    .frame_byte1_i     (frame_byte1_i),
    .frame_byte2_i     (frame_byte2_i),
    .frame_byte3_i     (frame_byte3_i),
    .frame_byte4_i     (frame_byte4_i),
    .frame_byte5_i     (frame_byte5_i),
    .frame_byte6_i     (frame_byte6_i),
    .frame_byte7_i     (frame_byte7_i),
    .read_index_i      (read_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .message_length_o  (message_length_o),
    .service_byte_o    (service_byte_o),
    .info_byte_o       (info_byte_o),
    .collected_count_o (collected_count_o),
    .read_data_o       (read_data_o)
  );

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  // every field random; callers then shape the parts that matter
  function automatic frame_t base_frame(logic [1:0] mode);
    frame_t f;
    int     i;
    f.mode = mode;
    f.src  = $urandom();
    f.dlen = $urandom_range(0, 15);
    for (i = 0; i < 8; i++) f.fb[i] = $urandom();
    f.ridx = $urandom();
    return f;
  endfunction

  function automatic frame_t first_frame(logic [28:0] src, logic [11:0] total,
                                         logic [3:0] dlen);
    frame_t f;
    f       = base_frame(MODE_FIRST);
    f.src   = src;
    f.dlen  = dlen;
    f.fb[0] = {PCI_FIRST, total[11:8]};
    f.fb[1] = total[7:0];
    return f;
  endfunction

  function automatic frame_t consec_frame(logic [28:0] src, logic [3:0] pci,
                                          logic [3:0] seq, logic [3:0] dlen);
    frame_t f;
    f       = base_frame(MODE_CONSEC);
    f.src   = src;
    f.dlen  = dlen;
    f.fb[0] = {pci, seq};
    return f;
  endfunction

  // a negative index picks one of the positions written so far; positions
  // never written since reset read back undefined, so they are never asked for
  function automatic frame_t read_frame(int idx);
    frame_t f;
    f = base_frame(MODE_READ);
    if (idx >= 0) begin
      f.ridx = idx;
    end else if (board.written_idx.size() != 0) begin
      f.ridx = board.written_idx[$urandom_range(0, board.written_idx.size() - 1)];
    end else begin
      f.mode = MODE_SPARE;
    end
    return f;
  endfunction

  function automatic frame_t noise_frame();
    frame_t f;
    f = base_frame($urandom_range(0, 3));
    if (f.mode == MODE_READ) f = read_frame(-1);
    return f;
  endfunction

  // mostly short messages, some past the store, a few up to the 12-bit limit
  function automatic logic [11:0] pick_total();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(0, 40);
    if (roll < 90) return $urandom_range(41, 300);
    if (roll < 98) return $urandom_range(301, 700);
    return $urandom_range(701, 4095);
  endfunction

  function automatic frame_t new_session();
    frame_t      f;
    logic [28:0] src;
    int unsigned roll;
    src  = ($urandom_range(0, 3) == 0) ? board.sender : 29'($urandom());
    f    = first_frame(src, pick_total(), $urandom_range(8, 15));
    roll = $urandom_range(0, 19);
    if (roll == 0) begin
      f.dlen = $urandom_range(0, 7);
    end else if (roll == 1) begin
      f.fb[0][7:4] = $urandom_range(2, 15);
    end
    return f;
  endfunction

  function automatic frame_t good_cf();
    int unsigned roll;
    logic [3:0]  dlen;
    roll = $urandom_range(0, 9);
    if (roll < 7) dlen = 4'd8;
    else if (roll < 9) dlen = $urandom_range(2, 7);
    else dlen = $urandom_range(9, 15);
    return consec_frame(board.sender, PCI_CONSEC, board.next_seq, dlen);
  endfunction

  // a consecutive frame spoilt in exactly one way
  function automatic frame_t broken_cf();
    frame_t f;
    f = good_cf();
    case ($urandom_range(0, 4))
      0: f.fb[0][3:0] = f.fb[0][3:0] + 4'($urandom_range(1, 15));
      1: f.src = f.src ^ (29'd1 << $urandom_range(0, 28));
      2: begin
        f.fb[0][7:4] = $urandom_range(0, 15);
        if (f.fb[0][7:4] == PCI_CONSEC) f.fb[0][7:4] = PCI_FIRST;
      end
      3: f.dlen = $urandom_range(0, 1);
      default: f.mode = MODE_SPARE;
    endcase
    return f;
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm_left = $urandom_range(30, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one item and returns at the edge that takes it. Valid stays high
  // across back-to-back items; it only drops when a gap is drawn or results are drained.
  task automatic send_frame(input frame_t f, inout int unsigned taken);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mode_i        <= f.mode;
    source_id_i   <= f.src;
    data_length_i <= f.dlen;
    frame_byte0_i <= f.fb[0];
    frame_byte1_i <= f.fb[1];
    frame_byte2_i <= f.fb[2];
    frame_byte3_i <= f.fb[3];
    frame_byte4_i <= f.fb[4];
    frame_byte5_i <= f.fb[5];
    frame_byte6_i <= f.fb[6];
    frame_byte7_i <= f.fb[7];
    read_index_i  <= f.ridx;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (board.note_frame(f)) taken++;
  endtask

  // stop offering and wait until every expected result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall runs, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned run_left;
    bit          run_stall;
    int unsigned hold_seen;
    int unsigned roll;
    run_left  = 0;
    run_stall = 1'b0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        run_stall = 1'b1;
        run_left  = HOLD_CYCLES;
      end else if (run_left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          run_stall = 1'b0;
          run_left  = $urandom_range(1, 8);
        end else if (roll < 80) begin
          run_stall = 1'b1;
          run_left  = $urandom_range(1, 3);
        end else if (roll < 92) begin
          run_stall = 1'b1;
          run_left  = $urandom_range(8, 40);
        end else begin
          run_stall = 1'b0;
          run_left  = $urandom_range(40, 150);
        end
      end
      out_stall_i <= run_stall;
      run_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every taken result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status  = status_o;
      got.msg_len = message_length_o;
      got.service = service_byte_o;
      got.info    = info_byte_o;
      got.count   = collected_count_o;
      got.rdata   = read_data_o;
      board.check_result(got);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    frame_t      f;
    int unsigned taken;
    int unsigned roll;
    bit          hold_sent;
    bit          pause_done;
    taken      = 0;
    hold_sent  = 1'b0;
    pause_done = 1'b0;
    board      = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // nothing open yet: spare mode code, orphan consecutive frame
    send_frame(base_frame(MODE_SPARE), taken);
    send_frame(consec_frame(29'd0, PCI_CONSEC, SEQ_FIRST, 4'd8), taken);
    // total of two: empty payload, complete straight away
    send_frame(first_frame(29'd7, 12'd2, 4'd8), taken);
    // first frame too short, then one with the wrong PCI nibble
    send_frame(first_frame(29'd7, 12'd20, 4'd7), taken);
    f = first_frame(29'd7, 12'd20, 4'd8);
    f.fb[0][7:4] = PCI_CONSEC;
    send_frame(f, taken);
    // widest sender id, payload exactly the four first-frame bytes
    send_frame(first_frame(29'h1FFFFFFF, 12'd6, 4'd15), taken);
    send_frame(read_frame(0), taken);
    send_frame(read_frame(3), taken);
    // longest message, then good and spoilt consecutive frames
    send_frame(first_frame(29'd0, 12'hFFF, 4'd8), taken);
    send_frame(consec_frame(29'd0, PCI_CONSEC, SEQ_FIRST, 4'd8), taken);
    send_frame(consec_frame(29'd1, PCI_CONSEC, 4'd2, 4'd8), taken);   // other sender
    send_frame(consec_frame(29'd0, PCI_CONSEC, 4'd3, 4'd8), taken);   // out of sequence
    send_frame(consec_frame(29'd0, PCI_CONSEC, 4'd2, 4'd1), taken);   // no data byte
    send_frame(consec_frame(29'd0, PCI_FIRST, 4'd2, 4'd8), taken);    // wrong PCI
    send_frame(consec_frame(29'd0, PCI_CONSEC, 4'd2, 4'd15), taken);  // long dlen, seven bytes
    send_frame(consec_frame(29'd0, PCI_CONSEC, 4'd3, 4'd2), taken);   // single byte
    send_frame(read_frame(10), taken);
    // seven-byte payload: the second frame is clipped, a third adds nothing
    send_frame(first_frame(29'd5, 12'd9, 4'd8), taken);
    send_frame(consec_frame(29'd5, PCI_CONSEC, SEQ_FIRST, 4'd8), taken);
    send_frame(consec_frame(29'd5, PCI_CONSEC, 4'd2, 4'd8), taken);
    send_frame(base_frame(MODE_SPARE), taken);
    send_frame(read_frame(6), taken);
    // totals below two
    send_frame(first_frame(29'd5, 12'd0, 4'd8), taken);
    send_frame(first_frame(29'd5, 12'd1, 4'd8), taken);
    drain_results();

    // --- random part: mostly whole sessions, some noise and spoilt frames ---
    taken = 0;
    while (taken < RANDOM_ITEMS) begin
      // long receiver hold-off while items keep coming, so the block backs up
      if (!hold_sent && taken >= RANDOM_ITEMS / 4) begin
        hold_req  <= hold_req + 1;
        hold_sent  = 1'b1;
      end
      // and once the sender waits for the block to empty completely
      if (!pause_done && taken >= RANDOM_ITEMS / 2) begin
        drain_results();
        pause_done = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (!board.active || roll < 1 ||
          (board.collected >= board.payload_len() && roll < 70)) begin
        send_frame(new_session(), taken);
      end else if (roll < 82) begin
        send_frame(good_cf(), taken);
      end else if (roll < 89) begin
        send_frame(broken_cf(), taken);
      end else if (roll < 96) begin
        send_frame(read_frame(-1), taken);
      end else begin
        send_frame(noise_frame(), taken);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
